// ===== rtl/ctc_pkg.sv =====
`default_nettype none

package ctc_pkg;

  localparam int TimeW = 13;

  // register indexes
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] CFG_ADD_STEP_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MAX_COOK_SECONDS = 2'd2;
  localparam logic [1:0] CFG_ALARM_SECONDS    = 2'd3;

  // register reset values
  localparam logic [9:0]       TPS_RESET       = 10'd100;
  localparam logic [7:0]       ADD_STEP_RESET  = 8'd30;
  localparam logic [TimeW-1:0] MAX_COOK_RESET  = 13'd3599;
  localparam logic [7:0]       ALARM_SEC_RESET = 8'd5;

  // func codes
  localparam logic [2:0] FUNC_DIGIT = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_ADD   = 3'd3;
  localparam logic [2:0] FUNC_DOOR  = 3'd4;
  localparam logic [2:0] FUNC_TICK  = 3'd5;

  // mode codes as seen on the output
  localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_CODE_ENTRY = 3'd1;
  localparam logic [2:0] MODE_CODE_COOK  = 3'd2;
  localparam logic [2:0] MODE_CODE_PAUSE = 3'd3;
  localparam logic [2:0] MODE_CODE_ALARM = 3'd4;
  localparam logic [2:0] MODE_CODE_DOOR  = 3'd5;

  // lamp bit positions
  localparam int LB_MAG   = 0;
  localparam int LB_LAMP  = 1;
  localparam int LB_ALARM = 2;

  localparam logic [TimeW-1:0] DISPLAY_LIMIT = 13'd5999;

  // x / 60 == (x * 8739) >> 19 for x up to 5999
  localparam logic [13:0] DIV60_MUL   = 14'd8739;
  localparam int          DIV60_SHIFT = 19;

  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_ENTRY = 6'b000010,
    M_COOK  = 6'b000100,
    M_PAUSE = 6'b001000,
    M_ALARM = 6'b010000,
    M_DOOR  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [9:0]       ticks_per_second;
    logic [7:0]       add_step_seconds;
    logic [TimeW-1:0] max_cook_seconds;
    logic [7:0]       alarm_seconds;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [2:0]       lamps;
    logic [TimeW-1:0] time_left;
    logic [TimeW-1:0] shown;
    logic             blank;
    logic [2:0]       count;
  } res_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [2:0]       lamps;
    logic [TimeW-1:0] time_left;
    logic [6:0]       minutes;
    logic [5:0]       seconds;
    logic             blank;
    logic [2:0]       count;
  } out_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      M_IDLE:  c = MODE_CODE_IDLE;
      M_ENTRY: c = MODE_CODE_ENTRY;
      M_COOK:  c = MODE_CODE_COOK;
      M_PAUSE: c = MODE_CODE_PAUSE;
      M_ALARM: c = MODE_CODE_ALARM;
      M_DOOR:  c = MODE_CODE_DOOR;
      default: c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  // mm:ss digits, first digit in the top nibble, to seconds
  function automatic logic [TimeW-1:0] entry_secs(input logic [15:0] d);
    logic [6:0] mm;
    logic [6:0] ss;
    mm = {3'b000, d[15:12]} * 7'd10 + {3'b000, d[11:8]};
    ss = {3'b000, d[7:4]} * 7'd10 + {3'b000, d[3:0]};
    return {6'b000000, mm} * 13'd60 + {6'b000000, ss};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ctc_state.sv =====
`default_nettype none

module ctc_state (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ctc_pkg::cfg_t cfg,
  input  logic [2:0]    func,
  input  logic [3:0]    key_digit,
  output ctc_pkg::res_t res
);
  import ctc_pkg::*;

  mode_t            mode, mode_next;
  logic [15:0]      entry, entry_next;
  logic [2:0]       count, count_next;
  logic [TimeW-1:0] time_left, time_left_next;
  logic [7:0]       alarm_count, alarm_count_next;
  logic [9:0]       prescale, prescale_next;
  logic [2:0]       lamps, lamps_next;
  logic             clr;
  logic [10:0]      prescale_inc;
  logic [7:0]       alarm_inc;
  logic [TimeW:0]   add_sum;
  logic [TimeW-1:0] start_secs;
  logic [TimeW-1:0] shown;
  logic             blank;

  assign prescale_inc = {1'b0, prescale} + 11'd1;
  assign alarm_inc    = alarm_count + 8'd1;
  assign add_sum      = {1'b0, time_left} + {6'b000000, cfg.add_step_seconds};
  assign start_secs   = entry_secs(entry);

  always_comb begin
    mode_next        = mode;
    entry_next       = entry;
    count_next       = count;
    time_left_next   = time_left;
    alarm_count_next = alarm_count;
    prescale_next    = prescale;
    lamps_next       = lamps;
    clr              = 1'b0;
    case (func)
      FUNC_DIGIT: begin
        if (key_digit <= 4'd9 && (mode == M_IDLE || mode == M_ENTRY)) begin
          if (count < 3'd4) begin
            entry_next = {entry[11:0], key_digit};
            if (!(count == 3'd0 && key_digit == 4'd0)) begin
              count_next = count + 3'd1;
            end
          end
          mode_next = M_ENTRY;
        end
      end
      FUNC_START: begin
        if (mode == M_ENTRY) begin
          time_left_next = start_secs;
          if (start_secs != '0) begin
            lamps_next = 3'b011;
            mode_next  = M_COOK;
          end
        end else if (mode == M_PAUSE) begin
          lamps_next = lamps | 3'b011;
          mode_next  = M_COOK;
        end
      end
      FUNC_STOP: begin
        if (mode == M_COOK) begin
          lamps_next = {lamps[LB_ALARM], 1'b1, 1'b0};
          mode_next  = M_PAUSE;
        end else if (mode != M_IDLE) begin
          clr = 1'b1;
        end
      end
      FUNC_ADD: begin
        if (mode == M_IDLE || mode == M_ENTRY || mode == M_COOK || mode == M_PAUSE) begin
          if (add_sum > {1'b0, cfg.max_cook_seconds}) begin
            time_left_next = cfg.max_cook_seconds;
          end else begin
            time_left_next = add_sum[TimeW-1:0];
          end
          lamps_next = lamps | 3'b011;
          mode_next  = M_COOK;
        end
      end
      FUNC_DOOR: begin
        if (mode == M_COOK) begin
          lamps_next = {lamps[LB_ALARM], 1'b1, 1'b0};
          mode_next  = M_DOOR;
        end else if (mode == M_DOOR) begin
          lamps_next = lamps | 3'b011;
          mode_next  = M_COOK;
        end
      end
      FUNC_TICK: begin
        if (prescale_inc >= {1'b0, cfg.ticks_per_second}) begin
          prescale_next = '0;
          if (mode == M_COOK) begin
            if (time_left != '0) begin
              time_left_next = time_left - 13'd1;
              if (time_left == 13'd1) begin
                lamps_next       = 3'b100;
                alarm_count_next = '0;
                mode_next        = M_ALARM;
              end
            end
          end else if (mode == M_ALARM) begin
            alarm_count_next = alarm_inc;
            lamps_next       = lamps ^ 3'b100;
            if (alarm_inc >= cfg.alarm_seconds) begin
              clr = 1'b1;
            end
          end
        end else begin
          prescale_next = prescale_inc[9:0];
        end
      end
      default: begin
      end
    endcase
    if (clr) begin
      entry_next     = '0;
      count_next     = '0;
      time_left_next = '0;
      lamps_next     = '0;
      mode_next      = M_IDLE;
    end
  end

  // raw shown time, clamped in the next stage
  always_comb begin
    shown = time_left_next;
    blank = 1'b0;
    case (mode_next)
      M_IDLE:  shown = '0;
      M_ENTRY: shown = entry_secs(entry_next);
      M_ALARM: begin
        shown = '0;
        blank = alarm_count_next[0];
      end
      default: shown = time_left_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      entry       <= '0;
      count       <= '0;
      time_left   <= '0;
      alarm_count <= '0;
      prescale    <= '0;
      lamps       <= '0;
    end else if (en) begin
      mode        <= mode_next;
      entry       <= entry_next;
      count       <= count_next;
      time_left   <= time_left_next;
      alarm_count <= alarm_count_next;
      prescale    <= prescale_next;
      lamps       <= lamps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.mode      <= mode_code(mode_next);
      res.lamps     <= lamps_next;
      res.time_left <= time_left_next;
      res.shown     <= shown;
      res.blank     <= blank;
      res.count     <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_mag_only_cooking: assert property (@(posedge clk) disable iff (rst)
    lamps[LB_MAG] |-> mode == M_COOK)
    else $error("magnetron on outside cooking");
  a_cook_lamps: assert property (@(posedge clk) disable iff (rst)
    mode == M_COOK |-> lamps[LB_MAG] && lamps[LB_LAMP] && !lamps[LB_ALARM])
    else $error("cooking without magnetron and lamp");
  a_alarm_lamp_mode: assert property (@(posedge clk) disable iff (rst)
    lamps[LB_ALARM] |-> mode == M_ALARM)
    else $error("alarm lamp on outside alarm");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("digit count above four");
`endif

endmodule

`default_nettype wire

// ===== rtl/ctc_display.sv =====
`default_nettype none

module ctc_display (
  input  logic                          clk,
  input  logic                          en_clamp,
  input  logic                          en_split,
  input  logic [ctc_pkg::TimeW-1:0]     max_cook_seconds,
  input  ctc_pkg::res_t                 res,
  output ctc_pkg::out_t                 out
);
  import ctc_pkg::*;

  res_t             clamped;
  logic [TimeW-1:0] limit;
  logic [TimeW-1:0] shown_lim;
  logic [26:0]      prod;
  logic [6:0]       quot;
  logic [TimeW-1:0] rem;

  assign limit     = (max_cook_seconds < DISPLAY_LIMIT) ? max_cook_seconds : DISPLAY_LIMIT;
  assign shown_lim = (res.shown > limit) ? limit : res.shown;

  always_ff @(posedge clk) begin
    if (en_clamp) begin
      clamped.mode      <= res.mode;
      clamped.lamps     <= res.lamps;
      clamped.time_left <= res.time_left;
      clamped.shown     <= shown_lim;
      clamped.blank     <= res.blank;
      clamped.count     <= res.count;
    end
  end

  // divide by 60 through the reciprocal
  assign prod = {14'd0, clamped.shown} * {13'd0, DIV60_MUL};
  assign quot = prod[DIV60_SHIFT+6:DIV60_SHIFT];
  assign rem  = clamped.shown - {6'd0, quot} * 13'd60;

  always_ff @(posedge clk) begin
    if (en_split) begin
      out.mode      <= clamped.mode;
      out.lamps     <= clamped.lamps;
      out.time_left <= clamped.time_left;
      out.minutes   <= quot;
      out.seconds   <= rem[5:0];
      out.blank     <= clamped.blank;
      out.count     <= clamped.count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cook_timer_controller.sv =====
`default_nettype none

// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  key or tick item
// m_*       out        m_tvalid/m_tready  mode, lamps and display per item
// cfg_*     in         cfg_we             register writes
//
// one item per cycle while m_tready allows; four register stages from input to
// result (input, state update, display clamp, divide by 60)
// the state registers loop back on themselves within the update stage
// each stage moves on when the stage after it is empty or moving
// rst is synchronous and clears the valid bits, the state and the config registers

module cook_timer_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // key_digit[3:0], zero fill
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // mode[2:0], magnetron_on, lamp_on, alarm_lamp_on,
                                 // remaining_seconds[12:0], display_minutes[6:0],
                                 // display_seconds[5:0], display_blank,
                                 // digits_entered[2:0], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  import ctc_pkg::*;

  cfg_t       cfg;
  logic       v1, v2, v3, v4;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic       en2, en3, en4;
  logic [2:0] func;
  logic [3:0] key_digit;
  res_t       res;
  out_t       out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= TPS_RESET;
      cfg.add_step_seconds <= ADD_STEP_RESET;
      cfg.max_cook_seconds <= MAX_COOK_RESET;
      cfg.alarm_seconds    <= ALARM_SEC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_wdata[9:0];
        CFG_ADD_STEP_SECONDS: cfg.add_step_seconds <= cfg_wdata[7:0];
        CFG_MAX_COOK_SECONDS: cfg.max_cook_seconds <= cfg_wdata;
        CFG_ALARM_SECONDS:    cfg.alarm_seconds    <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign en2  = v1 && rdy2;
  assign en3  = v2 && rdy3;
  assign en4  = v3 && rdy4;

  assign s_tready = rdy1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) begin
      func      <= s_tuser;
      key_digit <= s_tdata[3:0];
    end
  end

  ctc_state u_state (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .cfg       (cfg),
    .func      (func),
    .key_digit (key_digit),
    .res       (res)
  );

  ctc_display u_display (
    .clk              (clk),
    .en_clamp         (en3),
    .en_split         (en4),
    .max_cook_seconds (cfg.max_cook_seconds),
    .res              (res),
    .out              (out)
  );

  assign m_tdata = {4'b0000, out.count, out.blank, out.seconds, out.minutes,
                    out.time_left, out.lamps, out.mode};

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !v3 && !v4)
    else $error("pipeline not empty after reset");
  a_display_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out.seconds < 6'd60 && out.minutes <= 7'd99)
    else $error("display out of range");
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out.blank |-> out.minutes == 7'd0 && out.seconds == 6'd0)
    else $error("blank display shows time");
`endif

endmodule

`default_nettype wire
